/* src/msat_pkg.sv */
package msat_pkg;

	localparam int MAX_FIRE = 16;
	localparam int CNT_W    = $clog2(MAX_FIRE + 1);

	// A set with this timeout resumes the stored deadline.
	localparam logic signed [31:0] TMO_RESUME = -32'sd1;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} opcode_t;

	typedef struct packed {
		logic               opcode;
		logic [3:0]         slot;
		logic signed [31:0] timeout_ms;
	} req_t;

	typedef struct packed {
		logic       fired;
		logic [3:0] fired_slot;
		logic       last;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SET,
		S_ADV,
		S_SCAN,
		S_EVAL,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic cap;
		logic set;
		logic adv;
		logic scan_start;
		logic eval;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic found;
		logic full;
	} sts_t;

endpackage

/* src/msat_ctrl.sv */
module msat_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          opcode,
	input  msat_pkg::sts_t sts,
	output msat_pkg::cmd_t cmd,
	output logic          busy
);

	msat_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msat_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			msat_pkg::S_IDLE: begin
				if (start) begin
					state_d = (opcode == msat_pkg::OP_SET) ? msat_pkg::S_SET : msat_pkg::S_ADV;
				end
			end
			msat_pkg::S_SET:  state_d = msat_pkg::S_IDLE;
			msat_pkg::S_ADV:  state_d = msat_pkg::S_SCAN;
			msat_pkg::S_SCAN: begin
				if (sts.scan_done) begin
					state_d = msat_pkg::S_EVAL;
				end
			end
			msat_pkg::S_EVAL: begin
				if (!sts.found) begin
					state_d = msat_pkg::S_IDLE;
				end else if (sts.full) begin
					state_d = msat_pkg::S_FLUSH;
				end else begin
					state_d = msat_pkg::S_SCAN;
				end
			end
			msat_pkg::S_FLUSH: state_d = msat_pkg::S_IDLE;
			default:           state_d = msat_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			msat_pkg::S_IDLE: begin
				busy    = 1'b0;
				cmd.cap = start;
			end
			msat_pkg::S_SET: cmd.set = 1'b1;
			msat_pkg::S_ADV: begin
				cmd.adv        = 1'b1;
				cmd.scan_start = 1'b1;
			end
			msat_pkg::S_SCAN: ;
			msat_pkg::S_EVAL: begin
				cmd.eval = 1'b1;
				// Another pass is needed whenever a slot was just taken and room remains.
				cmd.scan_start = sts.found && !sts.full;
			end
			msat_pkg::S_FLUSH: cmd.flush = 1'b1;
			default: ;
		endcase
	end

endmodule

/* src/msat_dp.sv */
module msat_dp #(
	parameter int SLOTS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  msat_pkg::req_t request,
	input  msat_pkg::cmd_t cmd,
	output msat_pkg::sts_t sts,
	output logic           done,
	output msat_pkg::res_t result
);

	localparam int IW = $clog2(SLOTS);

	msat_pkg::req_t req_q;
	logic [63:0]    now_q;
	logic [SLOTS-1:0] armed_q, enabled_q;
	logic [63:0]    dl_mem [SLOTS];

	logic [IW-1:0]  addr_q;
	logic           scan_q;
	logic [63:0]    dl_s1;
	logic [IW-1:0]  idx_s1;
	logic           v_s1;

	logic           best_v_q;
	logic [IW-1:0]  best_idx_q;
	logic [63:0]    best_dl_q;
	logic           pend_v_q;
	logic [IW-1:0]  pend_idx_q;
	logic [msat_pkg::CNT_W-1:0] cnt_q;

	logic           done_q;
	msat_pkg::res_t res_q;

	logic           minus1, pos, zero, in_range;
	logic [IW-1:0]  sidx;
	logic           cand, better;
	logic           emit;
	msat_pkg::res_t res_d;

	assign minus1   = (req_q.timeout_ms == msat_pkg::TMO_RESUME);
	assign zero     = (req_q.timeout_ms == '0);
	assign pos      = !req_q.timeout_ms[31] && !zero;
	assign in_range = (32'(req_q.slot) < SLOTS);
	assign sidx     = IW'(req_q.slot);

	assign cand   = v_s1 && armed_q[idx_s1] && (dl_s1 <= now_q);
	assign better = cand && (!best_v_q || (dl_s1 < best_dl_q));

	assign sts.scan_done = v_s1 && (idx_s1 == IW'(SLOTS - 1));
	assign sts.found     = best_v_q;
	assign sts.full      = (cnt_q == msat_pkg::CNT_W'(msat_pkg::MAX_FIRE - 1));

	// A pending fire is held back until the next pass shows whether it is the last one.
	always_comb begin
		emit  = 1'b0;
		res_d = '0;
		if (cmd.set) begin
			emit       = 1'b1;
			res_d.last = 1'b1;
		end else if (cmd.eval) begin
			if (pend_v_q) begin
				emit             = 1'b1;
				res_d.fired      = 1'b1;
				res_d.fired_slot = 4'(pend_idx_q);
				res_d.last       = !best_v_q;
			end else if (!best_v_q) begin
				emit       = 1'b1;
				res_d.last = 1'b1;
			end
		end else if (cmd.flush) begin
			emit             = 1'b1;
			res_d.fired      = 1'b1;
			res_d.fired_slot = 4'(pend_idx_q);
			res_d.last       = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q     <= '0;
			armed_q   <= '0;
			enabled_q <= '0;
			scan_q    <= 1'b0;
			v_s1      <= 1'b0;
			best_v_q  <= 1'b0;
			pend_v_q  <= 1'b0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			addr_q    <= '0;
		end else begin
			done_q <= emit;
			v_s1   <= scan_q;

			if (cmd.adv) begin
				now_q    <= now_q + 64'd1;
				pend_v_q <= 1'b0;
				cnt_q    <= '0;
			end

			// Any timeout other than a resume disarms the slot before it is applied.
			if (cmd.set && in_range) begin
				if (pos) begin
					armed_q[sidx]   <= 1'b1;
					enabled_q[sidx] <= 1'b1;
				end else if (zero) begin
					armed_q[sidx]   <= 1'b0;
					enabled_q[sidx] <= 1'b0;
				end else if (minus1) begin
					if (enabled_q[sidx] && !armed_q[sidx]) begin
						armed_q[sidx] <= 1'b1;
					end
				end else begin
					armed_q[sidx] <= 1'b0;
				end
			end

			if (cmd.eval && best_v_q) begin
				armed_q[best_idx_q] <= 1'b0;
				pend_v_q            <= 1'b1;
				cnt_q               <= cnt_q + 1'b1;
			end

			if (cmd.scan_start) begin
				addr_q   <= '0;
				scan_q   <= 1'b1;
				best_v_q <= 1'b0;
			end else begin
				if (scan_q) begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == IW'(SLOTS - 1)) begin
						scan_q <= 1'b0;
					end
				end
				if (better) begin
					best_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_q <= request;
		end
		idx_s1 <= addr_q;
		if (better) begin
			best_idx_q <= idx_s1;
			best_dl_q  <= dl_s1;
		end
		if (cmd.eval && best_v_q) begin
			pend_idx_q <= best_idx_q;
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set && in_range && pos) begin
			dl_mem[sidx] <= now_q + 64'(unsigned'(req_q.timeout_ms));
		end
		dl_s1 <= dl_mem[addr_q];
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

/* src/multi_slot_alarm_timer_core.sv */
// Set request: one acknowledgment result, registered from the set state.
// Tick request: one pass over all slots per fired result, plus a closing pass that finds none unless
// sixteen fire, through a single deadline comparator and one deadline memory port; the tick holds
// busy until its final result is issued.
// Fired results follow one pass apart; the sixteenth comes from the flush state, with no pass.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Reset clears the clock, all armed and enable bits, and the controller; no clearing pass.
module multi_slot_alarm_timer_core #(
	parameter int SLOTS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  msat_pkg::req_t request,
	output logic           done,
	output msat_pkg::res_t result
);

	msat_pkg::cmd_t cmd;
	msat_pkg::sts_t sts;

	msat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (request.opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	msat_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.done    (done),
		.result  (result)
	);

endmodule

/* src/msat_checker.sv */
module msat_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input msat_pkg::req_t request,
	input logic           done,
	input msat_pkg::res_t result
);

	// An acknowledgment is always the final result of its request and names no slot.
	a_ack_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.fired |-> result.last && (result.fired_slot == 4'd0))
		else $error("acknowledgment with slot or without last");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	// A new request never reports its first result directly after the final result of the last one.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.last |=> !done)
		else $error("result directly after a final result");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.last |-> busy)
		else $error("non-final result while idle");

endmodule

bind multi_slot_alarm_timer_core msat_checker u_chk (.*);

/* verif/multi_slot_alarm_timer_checker.sv */
module multi_slot_alarm_timer_checker #(
	parameter int SLOTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  msat_pkg::req_t   request,
	input  logic             done,
	input  msat_pkg::res_t   result,
	output int               failures,
	output int               outstanding
);

	import msat_pkg::*;

	logic [63:0] clock_ms;
	logic [63:0] alarm_deadline [SLOTS];
	logic        alarm_armed    [SLOTS];
	logic        alarm_enabled  [SLOTS];

	res_t        alarm_results_due [$];
	res_t        want;

	// Applies one request to the local copy of the slot bank and queues what it reports.
	task automatic predict_alarm_results(input req_t req);
		logic signed [31:0] tmo;
		int                 s;
		int                 best;
		int                 n;
		res_t               ack;
		res_t               tail;
		ack = '{fired: 1'b0, fired_slot: 4'd0, last: 1'b1};
		if (req.opcode == OP_SET) begin
			tmo = req.timeout_ms;
			s = int'(req.slot);
			if (s < SLOTS) begin
				if (alarm_armed[s] && tmo != TMO_RESUME)
					alarm_armed[s] = 1'b0;
				if (tmo > 0) begin
					alarm_deadline[s] = clock_ms + {32'd0, tmo};
					alarm_armed[s] = 1'b1;
					alarm_enabled[s] = 1'b1;
				end else if (tmo == 0) begin
					alarm_enabled[s] = 1'b0;
				end else if (tmo == TMO_RESUME && alarm_enabled[s] && !alarm_armed[s]) begin
					alarm_armed[s] = 1'b1;
				end
			end
			alarm_results_due.push_back(ack);
		end else begin
			clock_ms = clock_ms + 64'd1;
			n = 0;
			best = 0;
			// Earliest deadline first; a strict compare keeps ties on the lower index.
			while (n < MAX_FIRE && best >= 0) begin
				best = -1;
				for (int i = 0; i < SLOTS; i++) begin
					if (alarm_armed[i] && alarm_deadline[i] <= clock_ms &&
					    (best < 0 || alarm_deadline[i] < alarm_deadline[best]))
						best = i;
				end
				if (best >= 0) begin
					alarm_armed[best] = 1'b0;
					alarm_results_due.push_back('{fired: 1'b1, fired_slot: 4'(best),
						last: 1'b0});
					n++;
				end
			end
			if (n == 0) begin
				alarm_results_due.push_back(ack);
			end else begin
				tail = alarm_results_due.pop_back();
				tail.last = 1'b1;
				alarm_results_due.push_back(tail);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_ms = '0;
			for (int i = 0; i < SLOTS; i++) begin
				alarm_deadline[i] = '0;
				alarm_armed[i] = 1'b0;
				alarm_enabled[i] = 1'b0;
			end
			alarm_results_due.delete();
			failures = 0;
			outstanding <= 0;
		end else begin
			// Results are checked before the request taken at this edge is predicted,
			// since a request never reports at the edge that takes it.
			if (done) begin
				if (alarm_results_due.size() == 0) begin
					failures++;
					$display("%0t: result with none expected: got fired=%0b slot=%0d last=%0b",
						$time, result.fired, result.fired_slot, result.last);
				end else begin
					want = alarm_results_due.pop_front();
					if (result.fired !== want.fired || result.fired_slot !== want.fired_slot ||
					    result.last !== want.last) begin
						failures++;
						$display({"%0t: result mismatch: expected fired=%0b slot=%0d last=%0b,",
							" got fired=%0b slot=%0d last=%0b"}, $time, want.fired,
							want.fired_slot, want.last, result.fired, result.fired_slot,
							result.last);
					end
				end
			end
			if (start && !busy)
				predict_alarm_results(request);
			outstanding <= alarm_results_due.size();
		end
	end

endmodule

/* verif/multi_slot_alarm_timer_core_tb.sv */
module multi_slot_alarm_timer_core_tb;

	import msat_pkg::*;

	localparam int SLOTS         = 16;
	localparam int RANDOM_ITEMS  = 200;
	localparam int QUIET_LIMIT   = 50 * (SLOTS + 2);
	localparam int SETTLE_CYCLES = 4 * (SLOTS + 2);

	logic clk;
	logic arst_n  = 1'b0;
	logic start   = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	res_t result;

	int fail_count;
	int outstanding;
	int quiet_cycles = 0;
	int burst_left   = 0;

	multi_slot_alarm_timer_core #(
		.SLOTS(SLOTS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	multi_slot_alarm_timer_checker #(
		.SLOTS(SLOTS)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.failures   (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// A stall of the run shows up as a long stretch with no request taken and no result.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("multi_slot_alarm_timer_core_tb: errors");
				$finish;
			end
		end
	end

	function automatic req_t alarm_req(input opcode_t op, input logic [3:0] s,
		input logic signed [31:0] t);
		req_t r;
		r.opcode = op;
		r.slot = s;
		r.timeout_ms = t;
		return r;
	endfunction

	// Mostly ticks and short timeouts so slots fire often; the rest exercises resume,
	// disable, negative values and the full 32-bit range.
	function automatic req_t random_alarm_req();
		req_t        r;
		int unsigned pick;
		r.slot = 4'($urandom);
		r.timeout_ms = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			r.opcode = OP_TICK;
		end else begin
			r.opcode = OP_SET;
			pick = $urandom_range(0, 99);
			if (pick < 40)
				r.timeout_ms = $urandom_range(1, 24);
			else if (pick < 60)
				r.timeout_ms = TMO_RESUME;
			else if (pick < 70)
				r.timeout_ms = 32'sd0;
			else if (pick < 80)
				r.timeout_ms = {1'b1, 31'($urandom)};
			else if (pick < 90)
				r.timeout_ms = $urandom_range(25, 2000);
		end
		return r;
	endfunction

	// Holds start through the request until the block takes it; gaps fall between bursts.
	task automatic send_request(input req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
				: $urandom_range(1, 8);
		end
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		burst_left--;
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Empty tick, then the timeout extremes and the resume and disarm corner cases.
		send_request(alarm_req(OP_TICK, 4'd0, 32'sd0));
		send_request(alarm_req(OP_SET, 4'd1, 32'sh7fffffff));
		send_request(alarm_req(OP_SET, 4'd1, TMO_RESUME));
		send_request(alarm_req(OP_SET, 4'd1, -32'sd2));
		send_request(alarm_req(OP_SET, 4'd2, 32'sh80000000));
		send_request(alarm_req(OP_SET, 4'd1, 32'sd0));
		send_request(alarm_req(OP_SET, 4'd1, TMO_RESUME));

		// Every slot due on the same tick: sixteen results, ties in index order.
		for (int i = 0; i < SLOTS; i++)
			send_request(alarm_req(OP_SET, 4'(i), 32'sd1));
		send_request(alarm_req(OP_TICK, 4'd15, TMO_RESUME));

		// Resumed slots whose deadlines have passed fire on the next tick.
		send_request(alarm_req(OP_SET, 4'd9, TMO_RESUME));
		send_request(alarm_req(OP_SET, 4'd4, TMO_RESUME));
		send_request(alarm_req(OP_TICK, 4'd0, 32'sd0));
		wait_for_results();

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS / 2)
				wait_for_results();
			send_request(random_alarm_req());
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("multi_slot_alarm_timer_core_tb: clean");
		else
			$display("multi_slot_alarm_timer_core_tb: errors");
		$finish;
	end

endmodule
